// ----- sv/mie_pkg.sv -----
// Package for the instruction execute core: payload words, opcodes, modes,
// data memory addresses and the control word of the shared arithmetic unit.
// No dependencies.
package mie_pkg;

    localparam int DATA_BYTES  = 4096;
    localparam int DMEM_AW     = $clog2(DATA_BYTES);
    localparam int FLASH_WORDS = 16384;
    localparam int FLASH_AW    = $clog2(FLASH_WORDS);

    // Item modes
    localparam logic [1:0] MODE_EXEC  = 2'd0;
    localparam logic [1:0] MODE_FLASH = 2'd1;
    localparam logic [1:0] MODE_READ  = 2'd2;

    // Opcodes
    localparam logic [4:0] OP_ADIW = 5'd0;
    localparam logic [4:0] OP_SBIW = 5'd1;
    localparam logic [4:0] OP_ADD  = 5'd2;
    localparam logic [4:0] OP_ADC  = 5'd3;
    localparam logic [4:0] OP_CP   = 5'd4;
    localparam logic [4:0] OP_CPC  = 5'd5;
    localparam logic [4:0] OP_CPI  = 5'd6;
    localparam logic [4:0] OP_EOR  = 5'd7;
    localparam logic [4:0] OP_LDI  = 5'd8;
    localparam logic [4:0] OP_LDS  = 5'd9;
    localparam logic [4:0] OP_STS  = 5'd10;
    localparam logic [4:0] OP_IN   = 5'd11;
    localparam logic [4:0] OP_OUT  = 5'd12;
    localparam logic [4:0] OP_LPM  = 5'd13;
    localparam logic [4:0] OP_STX  = 5'd14;
    localparam logic [4:0] OP_PUSH = 5'd15;
    localparam logic [4:0] OP_POP  = 5'd16;
    localparam logic [4:0] OP_CALL = 5'd17;
    localparam logic [4:0] OP_RCALL = 5'd18;
    localparam logic [4:0] OP_RET  = 5'd19;
    localparam logic [4:0] OP_JMP  = 5'd20;
    localparam logic [4:0] OP_RJMP = 5'd21;
    localparam logic [4:0] OP_BRGE = 5'd22;
    localparam logic [4:0] OP_BRNE = 5'd23;

    // Data memory map
    localparam logic [15:0] IO_BASE   = 16'h0020;
    localparam logic [15:0] SPL_ADDR  = 16'h005D;
    localparam logic [15:0] SPH_ADDR  = 16'h005E;
    localparam logic [15:0] SREG_ADDR = 16'h005F;
    localparam logic [15:0] X_LO_ADDR = 16'd26;
    localparam logic [15:0] X_HI_ADDR = 16'd27;
    localparam logic [15:0] Z_LO_ADDR = 16'd30;
    localparam logic [15:0] Z_HI_ADDR = 16'd31;

    // Status bit positions
    localparam int FLAG_C = 0;
    localparam int FLAG_Z = 1;
    localparam int FLAG_N = 2;
    localparam int FLAG_V = 3;
    localparam int FLAG_S = 4;
    localparam int FLAG_H = 5;

    typedef enum logic [2:0] {
        ALU_ADD8,
        ALU_SUB8,
        ALU_XOR8,
        ALU_ADD16,
        ALU_SUB16
    } t_alu_op;

    typedef struct packed {
        t_alu_op op;
        logic    cin;
        logic    chain;
    } t_alu_ctl;

    typedef struct packed {
        logic [1:0]         mode;
        logic [4:0]         opcode;
        logic [4:0]         reg_d;
        logic [4:0]         reg_r;
        logic [7:0]         immediate;
        logic [1:0]         reg_pair;
        logic [15:0]        target_address;
        logic signed [11:0] rel_offset;
        logic [5:0]         io_address;
        logic [1:0]         instr_words;
        logic [15:0]        flash_word;
    } t_in_word;

    typedef struct packed {
        logic [15:0] program_counter_out;
        logic [7:0]  status_out;
        logic [7:0]  read_byte;
        logic        unimplemented;
    } t_out_word;

endpackage

// ----- sv/mie_alu.sv -----
// Shared arithmetic unit: byte add, compare, xor and word add/subtract with
// status flag update. Depends on mie_pkg.
module mie_alu import mie_pkg::*; (
    input  t_alu_ctl    i_ctl,
    input  logic [15:0] i_a,
    input  logic [15:0] i_b,
    input  logic [7:0]  i_sreg,
    output logic [15:0] o_res,
    output logic [7:0]  o_sreg
);

    logic [8:0]  sum9;
    logic [4:0]  half;
    logic [7:0]  diff8;
    logic [7:0]  xor8;
    logic [15:0] sum16;
    logic [15:0] dif16;
    logic [7:0]  flags;
    logic [7:0]  mask;
    logic [7:0]  merged;

    always_comb begin
        sum9   = {1'b0, i_a[7:0]} + {1'b0, i_b[7:0]} + 9'(i_ctl.cin);
        half   = {1'b0, i_a[3:0]} + {1'b0, i_b[3:0]} + 5'(i_ctl.cin);
        diff8  = i_a[7:0] - i_b[7:0] - 8'(i_ctl.cin);
        xor8   = i_a[7:0] ^ i_b[7:0];
        sum16  = i_a + i_b;
        dif16  = i_a - i_b;
        flags  = 8'h00;
        mask   = 8'h00;
        o_res  = sum16;
        case (i_ctl.op)
            ALU_ADD8: begin
                o_res         = {8'h00, sum9[7:0]};
                flags[FLAG_H] = half[4];
                flags[FLAG_V] = ~(i_a[7] ^ i_b[7]) & (i_a[7] ^ sum9[7]);
                flags[FLAG_N] = sum9[7];
                flags[FLAG_Z] = (sum9[7:0] == 8'h00);
                flags[FLAG_C] = sum9[8];
                mask          = 8'h2F;
            end
            ALU_SUB8: begin
                // compare: H left alone, chained Z can only clear
                o_res         = {8'h00, diff8};
                flags[FLAG_V] = (i_a[7] ^ i_b[7]) & (i_a[7] ^ diff8[7]);
                flags[FLAG_N] = diff8[7];
                flags[FLAG_Z] = (diff8 == 8'h00) && (!i_ctl.chain || i_sreg[FLAG_Z]);
                flags[FLAG_C] = ({1'b0, i_b[7:0]} + 9'(i_ctl.cin)) > {1'b0, i_a[7:0]};
                mask          = 8'h0F;
            end
            ALU_XOR8: begin
                o_res         = {8'h00, xor8};
                flags[FLAG_N] = xor8[7];
                flags[FLAG_Z] = (xor8 == 8'h00);
                mask          = 8'h0E;
            end
            ALU_ADD16: begin
                o_res         = sum16;
                flags[FLAG_V] = !i_a[15] && sum16[15];
                flags[FLAG_N] = sum16[15];
                flags[FLAG_Z] = (sum16 == 16'h0000);
                flags[FLAG_C] = i_a[15] && !sum16[15];
                mask          = 8'h0F;
            end
            ALU_SUB16: begin
                o_res         = dif16;
                flags[FLAG_V] = i_a[15] && !dif16[15];
                flags[FLAG_N] = dif16[15];
                flags[FLAG_Z] = (dif16 == 16'h0000);
                flags[FLAG_C] = dif16[15] && !i_a[15];
                mask          = 8'h0F;
            end
            default: begin
                o_res = sum16;
                mask  = 8'h00;
            end
        endcase
        merged         = (i_sreg & ~mask) | (flags & mask);
        merged[FLAG_S] = merged[FLAG_N] ^ merged[FLAG_V];
        o_sreg         = merged;
    end

endmodule

// ----- sv/mie_dmem.sv -----
// Single-port data memory with registered read and a clearing sweep after
// reset. Out-of-range reads give zero, out-of-range writes drop. Uses mie_pkg.
module mie_dmem import mie_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_we,
    input  logic [15:0] i_addr,
    input  logic [7:0]  i_wdata,
    output logic [7:0]  o_rdata,
    output logic        o_busy
);

    logic [7:0]         r_mem [DATA_BYTES];
    logic [7:0]         r_q;
    logic               r_oor;
    logic               r_busy;
    logic [DMEM_AW-1:0] r_clr;
    logic               in_range;

    assign in_range = ({1'b0, i_addr} < 17'(DATA_BYTES));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b1;
            r_clr  <= '0;
        end else if (r_busy) begin
            r_clr <= r_clr + 1'b1;
            if (r_clr == DMEM_AW'(DATA_BYTES - 1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_busy) begin
            r_mem[r_clr] <= 8'h00;
        end else if (i_we && in_range) begin
            r_mem[i_addr[DMEM_AW-1:0]] <= i_wdata;
        end
        r_q   <= r_mem[i_addr[DMEM_AW-1:0]];
        r_oor <= !in_range;
    end

    assign o_rdata = r_oor ? 8'h00 : r_q;
    assign o_busy  = r_busy;

endmodule

// ----- sv/mie_flash.sv -----
// Program flash: one word written or read per cycle, read data registered.
// Addresses beyond the array drop writes and read zero. Uses mie_pkg.
module mie_flash import mie_pkg::*; (
    input  logic        i_clk,
    input  logic        i_we,
    input  logic [15:0] i_addr,
    input  logic [15:0] i_wdata,
    output logic [15:0] o_rdata
);

    logic [15:0] r_mem [FLASH_WORDS];
    logic [15:0] r_q;
    logic        r_oor;
    logic        in_range;

    assign in_range = ({1'b0, i_addr} < 17'(FLASH_WORDS));

    always_ff @(posedge i_clk) begin
        if (i_we && in_range) begin
            r_mem[i_addr[FLASH_AW-1:0]] <= i_wdata;
        end
        r_q   <= r_mem[i_addr[FLASH_AW-1:0]];
        r_oor <= !in_range;
    end

    assign o_rdata = r_oor ? 16'h0000 : r_q;

endmodule

// ----- sv/mcu_instruction_execute_core.sv -----
// Top level of the instruction execute core: sequencer around the shared
// arithmetic unit, the data memory and the program flash. Uses mie_pkg.
//
// Each input word executes one pre-decoded instruction, writes one flash
// word or reads one data byte, and yields exactly one output word carrying
// the program counter, the status byte, the read byte and the unimplemented
// bit. Registers, I/O space, stack pointer and status byte all sit in one
// single-port data memory, so the sequencer makes its memory accesses one
// at a time. Flash writes and jumps are the shortest items and a return,
// with its two pops, the longest; word arithmetic takes longer than byte
// arithmetic. The result comes out in the same cycle as the input turns
// ready again, and a stalled output holds the sequencer until it is taken.
// The input is not ready while an item is in work. After reset the data
// memory is swept to zero, one byte a cycle, so the first word is taken
// only after the sweep has cleared all DATA_BYTES (4096) bytes. A finished
// result waits in the output register while the next word is accepted.
module mcu_instruction_execute_core import mie_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_word  i_in_word,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_word o_out_word
);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_EXEC,
        S_SREG,
        S_STAT
    } t_state;

    t_state      r_state, n_state;
    logic [3:0]  r_step, n_step;
    t_in_word    r_in, n_in;
    logic [15:0] r_pc, n_pc;
    logic [7:0]  r_s, n_s;
    logic [7:0]  r_lo, n_lo;
    logic [7:0]  r_b, n_b;
    logic [15:0] r_p, n_p;
    logic [15:0] r_res, n_res;
    logic [7:0]  r_ns, n_ns;
    logic        r_unimpl, n_unimpl;
    logic [7:0]  r_rb, n_rb;
    logic        r_out_valid, n_out_valid;
    t_out_word   r_out, n_out;

    logic        mem_we;
    logic [15:0] mem_addr;
    logic [7:0]  mem_wdata;
    logic [7:0]  mem_q;
    logic        dm_busy;
    logic        fl_we;
    logic [15:0] fl_addr;
    logic [15:0] fl_q;
    t_alu_ctl    alu_ctl;
    logic [15:0] alu_a, alu_b, alu_res;
    logic [7:0]  alu_sreg;

    logic [4:0]  op;
    logic [15:0] rd16, rr16, pair16, io16, next_pc, off16;
    logic        word_op, writes_rd, taken;

    mie_dmem u_dmem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (mem_we),
        .i_addr  (mem_addr),
        .i_wdata (mem_wdata),
        .o_rdata (mem_q),
        .o_busy  (dm_busy)
    );

    mie_flash u_flash (
        .i_clk   (i_clk),
        .i_we    (fl_we),
        .i_addr  (fl_addr),
        .i_wdata (r_in.flash_word),
        .o_rdata (fl_q)
    );

    mie_alu u_alu (
        .i_ctl  (alu_ctl),
        .i_a    (alu_a),
        .i_b    (alu_b),
        .i_sreg (r_s),
        .o_res  (alu_res),
        .o_sreg (alu_sreg)
    );

    // Decoded fields of the held word
    assign op        = r_in.opcode;
    assign rd16      = {11'd0, r_in.reg_d};
    assign rr16      = {11'd0, r_in.reg_r};
    assign pair16    = {11'd0, 2'b11, r_in.reg_pair, 1'b0};
    assign io16      = {10'd0, r_in.io_address} + IO_BASE;
    assign next_pc   = r_pc + 16'(r_in.instr_words);
    assign off16     = {{4{r_in.rel_offset[11]}}, r_in.rel_offset};
    assign word_op   = (op == OP_ADIW) || (op == OP_SBIW);
    assign writes_rd = !((op == OP_CP) || (op == OP_CPC) || (op == OP_CPI));
    assign taken     = (op == OP_BRGE) ? !mem_q[FLAG_S] : !mem_q[FLAG_Z];

    always_comb begin
        n_state     = r_state;
        n_step      = r_step + 4'd1;
        n_in        = r_in;
        n_pc        = r_pc;
        n_s         = r_s;
        n_lo        = r_lo;
        n_b         = r_b;
        n_p         = r_p;
        n_res       = r_res;
        n_ns        = r_ns;
        n_unimpl    = r_unimpl;
        n_rb        = r_rb;
        n_out       = r_out;
        n_out_valid = r_out_valid && !i_out_ready;
        mem_we      = 1'b0;
        mem_addr    = SREG_ADDR;
        mem_wdata   = 8'h00;
        fl_we       = 1'b0;
        fl_addr     = r_in.target_address;
        alu_ctl     = '{op: ALU_ADD16, cin: 1'b0, chain: 1'b0};
        alu_a       = r_p;
        alu_b       = 16'd1;

        case (r_state)
            S_CLEAR: begin
                if (!dm_busy) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    n_in     = i_in_word;
                    n_state  = S_EXEC;
                    n_step   = 4'd0;
                    n_rb     = 8'h00;
                    n_unimpl = 1'b0;
                end
            end
            S_EXEC: begin
                case (r_in.mode)
                    MODE_EXEC: begin
                        if (op <= OP_EOR) begin
                            // read status, two operands, compute, write back
                            case (r_step)
                                4'd0: mem_addr = SREG_ADDR;
                                4'd1: begin
                                    n_s      = mem_q;
                                    mem_addr = word_op ? pair16 : rd16;
                                end
                                4'd2: begin
                                    n_lo     = mem_q;
                                    mem_addr = word_op ? pair16 + 16'd1 : rr16;
                                end
                                4'd3: n_b = (op == OP_CPI) ? r_in.immediate : mem_q;
                                4'd4: begin
                                    case (op)
                                        OP_ADIW: alu_ctl.op = ALU_ADD16;
                                        OP_SBIW: alu_ctl.op = ALU_SUB16;
                                        OP_ADD, OP_ADC: alu_ctl.op = ALU_ADD8;
                                        OP_EOR: alu_ctl.op = ALU_XOR8;
                                        default: alu_ctl.op = ALU_SUB8;
                                    endcase
                                    alu_ctl.cin   = ((op == OP_ADC) || (op == OP_CPC)) &&
                                                    r_s[FLAG_C];
                                    alu_ctl.chain = (op == OP_CPC);
                                    alu_a = word_op ? {r_b, r_lo} : {8'h00, r_lo};
                                    alu_b = word_op ? {8'h00, r_in.immediate} : {8'h00, r_b};
                                    n_res = alu_res;
                                    n_ns  = alu_sreg;
                                    if (writes_rd) begin
                                        mem_we    = 1'b1;
                                        mem_addr  = word_op ? pair16 : rd16;
                                        mem_wdata = alu_res[7:0];
                                    end
                                end
                                4'd5: begin
                                    mem_we = 1'b1;
                                    if (word_op) begin
                                        mem_addr  = pair16 + 16'd1;
                                        mem_wdata = r_res[15:8];
                                    end else begin
                                        mem_addr  = SREG_ADDR;
                                        mem_wdata = r_ns;
                                        n_pc      = next_pc;
                                        n_state   = S_SREG;
                                    end
                                end
                                default: begin
                                    mem_we    = 1'b1;
                                    mem_addr  = SREG_ADDR;
                                    mem_wdata = r_ns;
                                    n_pc      = next_pc;
                                    n_state   = S_SREG;
                                end
                            endcase
                        end else begin
                            case (op)
                                OP_LDI: begin
                                    mem_we    = 1'b1;
                                    mem_addr  = rd16;
                                    mem_wdata = r_in.immediate;
                                    n_pc      = next_pc;
                                    n_state   = S_SREG;
                                end
                                OP_LDS, OP_IN, OP_STS, OP_OUT: begin
                                    if (r_step == 4'd0) begin
                                        case (op)
                                            OP_LDS:  mem_addr = r_in.target_address;
                                            OP_IN:   mem_addr = io16;
                                            default: mem_addr = rd16;
                                        endcase
                                    end else begin
                                        mem_we    = 1'b1;
                                        mem_wdata = mem_q;
                                        case (op)
                                            OP_STS:  mem_addr = r_in.target_address;
                                            OP_OUT:  mem_addr = io16;
                                            default: mem_addr = rd16;
                                        endcase
                                        n_pc    = next_pc;
                                        n_state = S_SREG;
                                    end
                                end
                                OP_LPM, OP_STX, OP_PUSH: begin
                                    // fetch pointer, move the byte, write pointer back
                                    case (r_step)
                                        4'd0: begin
                                            case (op)
                                                OP_LPM:  mem_addr = Z_LO_ADDR;
                                                OP_STX:  mem_addr = X_LO_ADDR;
                                                default: mem_addr = SPL_ADDR;
                                            endcase
                                        end
                                        4'd1: begin
                                            n_lo = mem_q;
                                            case (op)
                                                OP_LPM:  mem_addr = Z_HI_ADDR;
                                                OP_STX:  mem_addr = X_HI_ADDR;
                                                default: mem_addr = SPH_ADDR;
                                            endcase
                                        end
                                        4'd2: begin
                                            n_p      = {mem_q, r_lo};
                                            mem_addr = rd16;
                                            fl_addr  = {1'b0, mem_q, r_lo[7:1]};
                                        end
                                        4'd3: begin
                                            mem_we = 1'b1;
                                            alu_ctl.op = (op == OP_PUSH) ? ALU_SUB16 : ALU_ADD16;
                                            n_res  = alu_res;
                                            if (op == OP_LPM) begin
                                                mem_addr  = rd16;
                                                mem_wdata = r_p[0] ? fl_q[15:8] : fl_q[7:0];
                                            end else begin
                                                mem_addr  = r_p;
                                                mem_wdata = mem_q;
                                            end
                                        end
                                        4'd4: begin
                                            mem_we    = 1'b1;
                                            mem_wdata = r_res[7:0];
                                            case (op)
                                                OP_LPM:  mem_addr = Z_LO_ADDR;
                                                OP_STX:  mem_addr = X_LO_ADDR;
                                                default: mem_addr = SPL_ADDR;
                                            endcase
                                        end
                                        default: begin
                                            mem_we    = 1'b1;
                                            mem_wdata = r_res[15:8];
                                            case (op)
                                                OP_LPM:  mem_addr = Z_HI_ADDR;
                                                OP_STX:  mem_addr = X_HI_ADDR;
                                                default: mem_addr = SPH_ADDR;
                                            endcase
                                            n_pc    = next_pc;
                                            n_state = S_SREG;
                                        end
                                    endcase
                                end
                                OP_POP, OP_RET: begin
                                    // each pop: pre-increment SP, write it, read the byte
                                    case (r_step)
                                        4'd0, 4'd5: begin
                                            mem_addr = SPL_ADDR;
                                            if (r_step == 4'd5) begin
                                                n_b = mem_q;
                                            end
                                        end
                                        4'd1, 4'd6: begin
                                            n_lo     = mem_q;
                                            mem_addr = SPH_ADDR;
                                        end
                                        4'd2, 4'd7: begin
                                            alu_a     = {mem_q, r_lo};
                                            n_p       = alu_res;
                                            mem_we    = 1'b1;
                                            mem_addr  = SPL_ADDR;
                                            mem_wdata = alu_res[7:0];
                                        end
                                        4'd3, 4'd8: begin
                                            mem_we    = 1'b1;
                                            mem_addr  = SPH_ADDR;
                                            mem_wdata = r_p[15:8];
                                        end
                                        4'd4, 4'd9: begin
                                            mem_addr = r_p;
                                            if (op == OP_POP && r_step == 4'd4) begin
                                                n_step = 4'd10;
                                            end
                                        end
                                        default: begin
                                            if (op == OP_POP) begin
                                                mem_we    = 1'b1;
                                                mem_addr  = rd16;
                                                mem_wdata = mem_q;
                                                n_pc      = next_pc;
                                            end else begin
                                                n_pc = {r_b, mem_q};
                                            end
                                            n_state = S_SREG;
                                        end
                                    endcase
                                end
                                OP_CALL, OP_RCALL: begin
                                    // push return low byte, then high byte
                                    case (r_step)
                                        4'd0, 4'd5: mem_addr = SPL_ADDR;
                                        4'd1, 4'd6: begin
                                            n_lo     = mem_q;
                                            mem_addr = SPH_ADDR;
                                        end
                                        4'd2, 4'd7: begin
                                            n_p       = {mem_q, r_lo};
                                            mem_we    = 1'b1;
                                            mem_addr  = {mem_q, r_lo};
                                            mem_wdata = (r_step == 4'd2) ? next_pc[7:0] :
                                                                          next_pc[15:8];
                                        end
                                        4'd3, 4'd8: begin
                                            alu_ctl.op = ALU_SUB16;
                                            n_res      = alu_res;
                                            mem_we     = 1'b1;
                                            mem_addr   = SPL_ADDR;
                                            mem_wdata  = alu_res[7:0];
                                        end
                                        4'd4: begin
                                            mem_we    = 1'b1;
                                            mem_addr  = SPH_ADDR;
                                            mem_wdata = r_res[15:8];
                                        end
                                        default: begin
                                            mem_we    = 1'b1;
                                            mem_addr  = SPH_ADDR;
                                            mem_wdata = r_res[15:8];
                                            alu_a     = next_pc;
                                            alu_b     = off16;
                                            n_pc      = (op == OP_CALL) ? r_in.target_address :
                                                                          alu_res;
                                            n_state   = S_SREG;
                                        end
                                    endcase
                                end
                                OP_JMP: begin
                                    n_pc    = r_in.target_address;
                                    n_state = S_SREG;
                                end
                                OP_RJMP: begin
                                    alu_a   = next_pc;
                                    alu_b   = off16;
                                    n_pc    = alu_res;
                                    n_state = S_SREG;
                                end
                                OP_BRGE, OP_BRNE: begin
                                    if (r_step == 4'd0) begin
                                        mem_addr = SREG_ADDR;
                                    end else begin
                                        alu_a   = next_pc;
                                        alu_b   = off16;
                                        n_pc    = taken ? alu_res : next_pc;
                                        n_state = S_SREG;
                                    end
                                end
                                default: begin
                                    n_unimpl = 1'b1;
                                    n_state  = S_SREG;
                                end
                            endcase
                        end
                    end
                    MODE_FLASH: begin
                        fl_we   = 1'b1;
                        n_state = S_SREG;
                    end
                    MODE_READ: begin
                        if (r_step == 4'd0) begin
                            mem_addr = r_in.target_address;
                        end else begin
                            n_rb    = mem_q;
                            n_state = S_SREG;
                        end
                    end
                    default: n_state = S_SREG;
                endcase
            end
            S_SREG: begin
                mem_addr = SREG_ADDR;
                n_state  = S_STAT;
            end
            S_STAT: begin
                // hold the status read until the output register is free
                mem_addr = SREG_ADDR;
                if (!r_out_valid || i_out_ready) begin
                    n_out.program_counter_out = r_pc;
                    n_out.status_out          = mem_q;
                    n_out.read_byte           = r_rb;
                    n_out.unimplemented       = r_unimpl;
                    n_out_valid               = 1'b1;
                    n_state                   = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_step      <= 4'd0;
            r_pc        <= 16'h0000;
            r_out_valid <= 1'b0;
            r_unimpl    <= 1'b0;
            r_rb        <= 8'h00;
        end else begin
            r_state     <= n_state;
            r_step      <= n_step;
            r_pc        <= n_pc;
            r_out_valid <= n_out_valid;
            r_unimpl    <= n_unimpl;
            r_rb        <= n_rb;
        end
        r_in  <= n_in;
        r_s   <= n_s;
        r_lo  <= n_lo;
        r_b   <= n_b;
        r_p   <= n_p;
        r_res <= n_res;
        r_ns  <= n_ns;
        r_out <= n_out;
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

    a_no_accept_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        dm_busy |-> !o_in_ready)
        else $error("input ready during memory clear");

    a_accept_starts_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> (r_state == S_EXEC) && (r_step == 4'd0))
        else $error("accepted word did not start execution");

    a_mem_write_in_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_we |-> (r_state == S_EXEC) && (r_in.mode == MODE_EXEC))
        else $error("data memory written outside execution");

    a_flash_write_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fl_we |-> (r_state == S_EXEC) && (r_in.mode == MODE_FLASH))
        else $error("flash written outside flash mode");

    a_step_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EXEC) |-> (r_step <= 4'd10))
        else $error("sequencer step out of range");

endmodule
